@@ rtl/crt_pkg.sv @@
// Package for the command retransmit tracker: table size, codes, payload and
// control structs, and helpers that build result beats. No dependencies.
`timescale 1ns / 1ps

package crt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_ACK  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Result kinds.
    localparam logic KIND_MSG    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes.
    localparam logic [2:0] ST_SENT           = 3'd0;
    localparam logic [2:0] ST_BEGIN_HELD     = 3'd1;
    localparam logic [2:0] ST_NOT_CONTROLLER = 3'd2;
    localparam logic [2:0] ST_NO_ID          = 3'd3;
    localparam logic [2:0] ST_ACK_OK         = 3'd4;
    localparam logic [2:0] ST_ACK_UNEXPECTED = 3'd5;
    localparam logic [2:0] ST_TABLE_FULL     = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_NODE_IS_CONTROLLER = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMMAND_MSG_ID     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MSG_ID_VALID       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_MS         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RETRIES        = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] command_id;
        logic        is_begin;
        logic [63:0] cmd_payload;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [31:0] out_msg_id;
        logic [63:0] out_payload;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        node_is_controller;
        logic [31:0] command_msg_id;
        logic        msg_id_valid;
        logic [15:0] timeout_ms;
        logic [2:0]  max_retries;
    } t_cfg;

    typedef struct packed {
        logic [15:0] cmd_id;
        logic [31:0] sent_time;
        logic [3:0]  retry_count;
        logic [63:0] message;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_ram_req;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_out_push;

    function automatic t_out_item f_msg(input logic [31:0] msg_id, input logic [63:0] payload);
        t_out_item r;
        r.kind        = KIND_MSG;
        r.out_msg_id  = msg_id;
        r.out_payload = payload;
        r.status      = ST_SENT;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic t_out_item f_status(input logic [2:0] code);
        t_out_item r;
        r.kind        = KIND_STATUS;
        r.out_msg_id  = 32'd0;
        r.out_payload = 64'd0;
        r.status      = code;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/crt_entry_ram.sv @@
// Entry table storage: one write port and one read port with registered,
// enable-held read data. Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_entry_ram
    import crt_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/crt_out_reg.sv @@
// Output register for result beats; reports whether a new beat can be loaded.
// Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_out_reg
    import crt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_out_push i_push,
    output logic      o_space,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_valid;
    t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_item <= i_push.item;
        end
    end

    assign o_space     = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_item;

endmodule

@@ rtl/crt_engine.sv @@
// Request sequencer: scans the entry RAM one entry per cycle unless stalled,
// updates valid bits and entries, and stages result beats. Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_engine
    import crt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_space,
    output t_out_push o_push,
    output t_ram_req  o_ram,
    input  t_entry    i_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FINISH = 4'b0100,
        S_FLUSH  = 4'b1000
    } t_state;

    t_state                 r_state,       n_state;
    t_in_item               r_item,        n_item;
    logic [CNT_W-1:0]       r_rd_cnt,      n_rd_cnt;
    logic                   r_ev_vld,      n_ev_vld;
    logic [IDX_W-1:0]       r_ev_idx,      n_ev_idx;
    logic                   r_found,       n_found;
    logic [IDX_W-1:0]       r_found_idx,   n_found_idx;
    logic                   r_free_found,  n_free_found;
    logic [IDX_W-1:0]       r_free_idx,    n_free_idx;
    logic [TABLE_DEPTH-1:0] r_valid,       n_valid;
    logic                   r_begin_pend,  n_begin_pend;
    logic [63:0]            r_begin_msg,   n_begin_msg;
    logic                   r_hold_vld,    n_hold_vld;
    t_out_item              r_hold,        n_hold;

    logic        can_emit;
    logic        stall;
    logic        ev_entry_valid;
    logic [31:0] ev_age;
    logic        ev_expired;
    logic        ev_retry_ok;
    logic        is_tick;

    assign can_emit       = !r_hold_vld || i_out_space;
    assign is_tick        = (r_item.req_type == REQ_TICK);
    assign ev_entry_valid = r_valid[r_ev_idx];
    assign ev_age         = r_item.now_ms - i_rd_data.sent_time;
    assign ev_expired     = ev_entry_valid && (ev_age > {16'd0, i_cfg.timeout_ms});
    assign ev_retry_ok    = i_rd_data.retry_count <= {1'b0, i_cfg.max_retries};
    assign o_in_ready     = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_rd_cnt     = r_rd_cnt;
        n_ev_vld     = r_ev_vld;
        n_ev_idx     = r_ev_idx;
        n_found      = r_found;
        n_found_idx  = r_found_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        n_begin_pend = r_begin_pend;
        n_begin_msg  = r_begin_msg;
        n_hold_vld   = r_hold_vld;
        n_hold       = r_hold;
        stall        = 1'b0;
        o_push       = '0;
        o_ram        = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item       = i_in_data;
                    n_rd_cnt     = '0;
                    n_ev_vld     = 1'b0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = S_FLUSH;
                    case (i_in_data.req_type)
                        REQ_SEND: begin
                            n_hold_vld = 1'b1;
                            if (!i_cfg.node_is_controller) begin
                                n_hold = f_status(ST_NOT_CONTROLLER);
                            end else if (!i_cfg.msg_id_valid) begin
                                n_hold = f_status(ST_NO_ID);
                            end else if (i_in_data.is_begin) begin
                                n_begin_pend = 1'b1;
                                n_begin_msg  = i_in_data.cmd_payload;
                                n_hold       = f_status(ST_BEGIN_HELD);
                            end else begin
                                n_hold  = f_msg(i_cfg.command_msg_id, i_in_data.cmd_payload);
                                n_state = S_SCAN;
                            end
                        end
                        REQ_ACK: begin
                            if (!i_cfg.node_is_controller) begin
                                n_hold_vld = 1'b1;
                                n_hold     = f_status(ST_NOT_CONTROLLER);
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        REQ_TICK: begin
                            // The held begin command goes out only once the table is empty.
                            if (r_begin_pend && !(|r_valid)) begin
                                n_hold_vld   = 1'b1;
                                n_hold       = f_msg(i_cfg.command_msg_id, r_begin_msg);
                                n_begin_pend = 1'b0;
                            end
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_FLUSH;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_ev_vld) begin
                    if (is_tick) begin
                        if (ev_expired) begin
                            if (ev_retry_ok) begin
                                if (can_emit) begin
                                    if (r_hold_vld) begin
                                        o_push.valid = 1'b1;
                                        o_push.item  = r_hold;
                                    end
                                    n_hold_vld                = 1'b1;
                                    n_hold                    = f_msg(i_cfg.command_msg_id,
                                                                      i_rd_data.message);
                                    o_ram.wr_en               = 1'b1;
                                    o_ram.wr_addr             = r_ev_idx;
                                    o_ram.wr_data             = i_rd_data;
                                    o_ram.wr_data.retry_count = i_rd_data.retry_count + 4'd1;
                                    o_ram.wr_data.sent_time   = r_item.now_ms;
                                end else begin
                                    stall = 1'b1;
                                end
                            end else begin
                                n_valid[r_ev_idx] = 1'b0;
                            end
                        end
                    end else begin
                        if (ev_entry_valid && !r_found
                                && (i_rd_data.cmd_id == r_item.command_id)) begin
                            n_found     = 1'b1;
                            n_found_idx = r_ev_idx;
                        end
                        if (!ev_entry_valid && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_ev_idx;
                        end
                    end
                end

                // The read data register holds while stalled, so the entry is not lost.
                if (!stall) begin
                    if (r_rd_cnt != CNT_W'(TABLE_DEPTH)) begin
                        o_ram.rd_en   = 1'b1;
                        o_ram.rd_addr = r_rd_cnt[IDX_W-1:0];
                        n_ev_vld      = 1'b1;
                        n_ev_idx      = r_rd_cnt[IDX_W-1:0];
                        n_rd_cnt      = r_rd_cnt + CNT_W'(1);
                    end else begin
                        n_ev_vld = 1'b0;
                        n_state  = is_tick ? S_FLUSH : S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                if (can_emit) begin
                    if (r_hold_vld) begin
                        o_push.valid = 1'b1;
                        o_push.item  = r_hold;
                    end
                    n_hold_vld = 1'b1;
                    n_state    = S_FLUSH;
                    if (r_item.req_type == REQ_SEND) begin
                        if (r_found || r_free_found) begin
                            o_ram.wr_en                 = 1'b1;
                            o_ram.wr_addr               = r_found ? r_found_idx : r_free_idx;
                            o_ram.wr_data.cmd_id        = r_item.command_id;
                            o_ram.wr_data.sent_time     = r_item.now_ms;
                            o_ram.wr_data.retry_count   = 4'd0;
                            o_ram.wr_data.message       = r_item.cmd_payload;
                            n_valid[o_ram.wr_addr]      = 1'b1;
                            n_hold                      = f_status(ST_SENT);
                        end else begin
                            n_hold = f_status(ST_TABLE_FULL);
                        end
                    end else begin
                        if (r_found) begin
                            n_valid[r_found_idx] = 1'b0;
                            n_hold               = f_status(ST_ACK_OK);
                        end else begin
                            n_hold = f_status(ST_ACK_UNEXPECTED);
                        end
                    end
                end
            end

            S_FLUSH: begin
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (i_out_space) begin
                    o_push.valid     = 1'b1;
                    o_push.item      = r_hold;
                    o_push.item.last = 1'b1;
                    n_hold_vld       = 1'b0;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_cnt     <= '0;
            r_ev_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_valid      <= '0;
            r_begin_pend <= 1'b0;
            r_hold_vld   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_cnt     <= n_rd_cnt;
            r_ev_vld     <= n_ev_vld;
            r_found      <= n_found;
            r_free_found <= n_free_found;
            r_valid      <= n_valid;
            r_begin_pend <= n_begin_pend;
            r_hold_vld   <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_ev_idx    <= n_ev_idx;
        r_found_idx <= n_found_idx;
        r_free_idx  <= n_free_idx;
        r_begin_msg <= n_begin_msg;
        r_hold      <= n_hold;
    end

`ifndef SYNTH
    // A write back during the scan targets the entry under evaluation, never the one being read.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram.wr_en && o_ram.rd_en) |-> (o_ram.wr_addr != o_ram.rd_addr))
        else $error("entry RAM read and write hit the same entry");

    a_push_has_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> i_out_space)
        else $error("result beat pushed into a full output register");

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_vld)
        else $error("staged result left behind at end of item");

    a_last_from_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.item.last) |=> (r_state == S_IDLE))
        else $error("final beat pushed without returning to idle");
`endif

endmodule

@@ rtl/command_retransmit_tracker.sv @@
// Top level of the command retransmit tracker: configuration registers and
// the sequencer, entry RAM and output register. Depends on crt_pkg.
`timescale 1ns / 1ps

// Controller-side retransmit table with 16 entries held in a single-port-read
// RAM. Each item is processed on its own. A send that is refused, or a begin
// command that is held, goes from idle straight to the flush state. A tracked
// send, an accepted ack and a tick read the whole table one entry per cycle
// through the RAM read port, save while a tick's retransmit waits for output
// space. A send or an ack then updates the table in the finish state, and
// every item ends in the flush state. The output side can hold off a result
// beat and so stall the item. The output register lets the next item be
// accepted while the last result beat still waits to be taken. There is no
// clearing pass after reset; the per-entry valid bits clear at once.

module command_retransmit_tracker
    import crt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    t_cfg      r_cfg;
    t_out_push push;
    logic      out_space;
    t_ram_req  ram_req;
    t_entry    ram_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_is_controller <= 1'b1;
            r_cfg.command_msg_id     <= 32'd0;
            r_cfg.msg_id_valid       <= 1'b1;
            r_cfg.timeout_ms         <= 16'd1000;
            r_cfg.max_retries        <= 3'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NODE_IS_CONTROLLER: r_cfg.node_is_controller <= i_cfg_wdata[0];
                CFG_COMMAND_MSG_ID:     r_cfg.command_msg_id     <= i_cfg_wdata[31:0];
                CFG_MSG_ID_VALID:       r_cfg.msg_id_valid       <= i_cfg_wdata[0];
                CFG_TIMEOUT_MS:         r_cfg.timeout_ms         <= i_cfg_wdata[15:0];
                CFG_MAX_RETRIES:        r_cfg.max_retries        <= i_cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    crt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_space (out_space),
        .o_push      (push),
        .o_ram       (ram_req),
        .i_rd_data   (ram_rd_data)
    );

    crt_entry_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (ram_rd_data)
    );

    crt_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_space     (out_space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
